/* design/dop_pkg.sv */
// Shared types, codes and length-rule functions for the DHCP options parser.
// Depends on nothing; the step, queue and top files use it by scoped names.
package dop_pkg;

    localparam int unsigned RES_DEPTH = 4;
    localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
    localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam logic [3:0] KIND_LEASE   = 4'd9;
    localparam logic [3:0] KIND_MSGTYPE = 4'd10;
    localparam logic [3:0] KIND_SERVER  = 4'd11;
    localparam logic [3:0] KIND_RENEW   = 4'd12;
    localparam logic [3:0] KIND_REBIND  = 4'd13;
    localparam logic [3:0] KIND_DONE    = 4'd14;
    localparam logic [3:0] KIND_NONE    = 4'd15;

    localparam logic [1:0] ST_END_SEEN   = 2'd0;
    localparam logic [1:0] ST_DGRAM_END  = 2'd1;
    localparam logic [1:0] ST_OVERRUN    = 2'd2;
    localparam logic [1:0] ST_BAD_LENGTH = 2'd3;

    localparam logic [7:0] CODE_PAD      = 8'd0;
    localparam logic [7:0] CODE_LEASE    = 8'd51;
    localparam logic [7:0] CODE_MSGTYPE  = 8'd53;
    localparam logic [7:0] CODE_SERVER   = 8'd54;
    localparam logic [7:0] CODE_RENEW    = 8'd58;
    localparam logic [7:0] CODE_REBIND   = 8'd59;
    localparam logic [7:0] CODE_END      = 8'd255;
    localparam logic [7:0] CODE_LAST_CHK = 8'd61;

    localparam logic [7:0] RULE_MULT4 = 8'h84;
    localparam logic [7:0] RULE_MULT2 = 8'h82;
    localparam logic [7:0] RULE_MULT1 = 8'h81;
    localparam logic [7:0] RULE_MIN1  = 8'h01;
    localparam logic [7:0] RULE_MIN2  = 8'h02;
    localparam logic [7:0] RULE_NONE  = 8'h00;

    typedef struct packed {
        logic [7:0] option_byte;
        logic       last_byte;
    } opt_item_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] value;
        logic [1:0]  status;
        logic        final_res;
    } res_item_t;

    typedef struct packed {
        logic [1:0] count;
        res_item_t  first;
        res_item_t  second;
    } res_push_t;

    function automatic logic [7:0] len_rule(input logic [7:0] code);
        logic [7:0] rule;
        unique case (code)
            8'd1, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9: rule = RULE_MULT4;
            8'd2:  rule = RULE_MULT2;
            8'd15: rule = RULE_MIN1;
            8'd53: rule = RULE_MULT1;
            8'd54: rule = RULE_MULT4;
            8'd56: rule = RULE_MIN1;
            8'd57: rule = RULE_MULT2;
            8'd58: rule = RULE_MULT4;
            8'd59: rule = RULE_MULT4;
            8'd61: rule = RULE_MIN2;
            default: rule = RULE_NONE;
        endcase
        return rule;
    endfunction

    function automatic logic length_ok(input logic [7:0] code, input logic [7:0] len);
        logic [7:0] rule;
        logic       ok;
        rule = len_rule(code);
        if (code == CODE_PAD || code > CODE_LAST_CHK) begin
            ok = 1'b1;
        end
        else if (rule[7]) begin
            if (len == 8'd0) begin
                ok = 1'b0;
            end
            else begin
                unique case (rule[6:0])
                    7'd4:    ok = (len[1:0] == 2'd0);
                    7'd2:    ok = (len[0] == 1'b0);
                    default: ok = 1'b1;
                endcase
            end
        end
        else begin
            ok = (len >= rule);
        end
        return ok;
    endfunction

    function automatic logic [3:0] kind_of(input logic [7:0] code);
        logic [3:0] kind;
        if (code >= 8'd1 && code <= 8'd9) begin
            kind = 4'(code - 8'd1);
        end
        else begin
            unique case (code)
                CODE_LEASE:   kind = KIND_LEASE;
                CODE_MSGTYPE: kind = KIND_MSGTYPE;
                CODE_SERVER:  kind = KIND_SERVER;
                CODE_RENEW:   kind = KIND_RENEW;
                CODE_REBIND:  kind = KIND_REBIND;
                default:      kind = KIND_NONE;
            endcase
        end
        return kind;
    endfunction

endpackage

/* design/dop_if.sv */
// Valid/ready channel interfaces for option bytes in and results out.
// Depends on nothing; the payload fields follow the parser's item layout.
interface dop_opt_if;
    logic       valid;
    logic       ready;
    logic [7:0] option_byte;
    logic       last_byte;

    modport source (output valid, output option_byte, output last_byte, input ready);
    modport sink (input valid, input option_byte, input last_byte, output ready);
endinterface

interface dop_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [31:0] value;
    logic [1:0]  status;
    logic        final_res;

    modport source (output valid, output kind, output value, output status,
                    output final_res, input ready);
    modport sink (input valid, input kind, input value, input status,
                  input final_res, output ready);
endinterface

/* design/dop_step.sv */
// Option record walker: holds the parse state and turns one accepted byte
// into zero, one or two results. Depends on dop_pkg.
module dop_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  dop_pkg::opt_item_t  item,
    output dop_pkg::res_push_t  push
);

    typedef enum logic [1:0] {
        PH_CODE = 2'd0,
        PH_LEN  = 2'd1,
        PH_VAL  = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  left_reg, left_next;
    logic [31:0] gather_reg, gather_next;
    logic [2:0]  count_reg, count_next;
    logic        stopped_reg, stopped_next;

    function automatic logic [31:0] param_value(input logic [3:0] kind,
                                                input logic [31:0] g,
                                                input logic [2:0] n);
        logic [31:0] v;
        if (kind == dop_pkg::KIND_MSGTYPE) begin
            unique case (n)
                3'd1:    v = {24'd0, g[7:0]};
                3'd2:    v = {24'd0, g[15:8]};
                3'd3:    v = {24'd0, g[23:16]};
                3'd4:    v = {24'd0, g[31:24]};
                default: v = 32'd0;
            endcase
        end
        else begin
            unique case (n)
                3'd1:    v = {g[7:0], 24'd0};
                3'd2:    v = {g[15:0], 16'd0};
                3'd3:    v = {g[23:0], 8'd0};
                3'd4:    v = g;
                default: v = 32'd0;
            endcase
        end
        return v;
    endfunction

    function automatic dop_pkg::res_item_t done_item(input logic [1:0] st);
        dop_pkg::res_item_t r;
        r.kind      = dop_pkg::KIND_DONE;
        r.value     = 32'd0;
        r.status    = st;
        r.final_res = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        logic [7:0]         b;
        logic               last;
        logic [3:0]         kind;
        logic               has_param;
        logic               has_done;
        logic [1:0]         done_st;
        logic               clear;
        logic [31:0]        g;
        logic [2:0]         c;
        logic [7:0]         left;
        dop_pkg::res_item_t p;

        b         = item.option_byte;
        last      = item.last_byte;
        kind      = dop_pkg::kind_of(code_reg);
        has_param = 1'b0;
        has_done  = 1'b0;
        done_st   = dop_pkg::ST_END_SEEN;
        clear     = 1'b0;
        g         = gather_reg;
        c         = count_reg;
        left      = left_reg - 8'd1;
        p         = '0;

        phase_next   = phase_reg;
        code_next    = code_reg;
        left_next    = left_reg;
        gather_next  = gather_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;

        if (accept) begin
            if (stopped_reg) begin
                if (last) begin
                    stopped_next = 1'b0;
                    clear        = 1'b1;
                end
            end
            else begin
                unique case (phase_reg)
                    PH_LEN:
                    begin
                        if (last && b != 8'd0) begin
                            has_done = 1'b1;
                            done_st  = dop_pkg::ST_OVERRUN;
                        end
                        else if (!dop_pkg::length_ok(code_reg, b)) begin
                            has_done = 1'b1;
                            done_st  = dop_pkg::ST_BAD_LENGTH;
                        end
                        else if (b == 8'd0) begin
                            has_param = (kind != dop_pkg::KIND_NONE);
                            p.kind    = kind;
                            clear     = 1'b1;
                            if (last) begin
                                has_done = 1'b1;
                                done_st  = dop_pkg::ST_DGRAM_END;
                            end
                        end
                        else begin
                            left_next   = b;
                            gather_next = 32'd0;
                            count_next  = 3'd0;
                            phase_next  = PH_VAL;
                        end
                    end
                    PH_VAL:
                    begin
                        if (count_reg < 3'd4) begin
                            g = {gather_reg[23:0], b};
                            c = count_reg + 3'd1;
                        end
                        if (left == 8'd0) begin
                            has_param = (kind != dop_pkg::KIND_NONE);
                            p.kind    = kind;
                            p.value   = param_value(kind, g, c);
                            clear     = 1'b1;
                            if (last) begin
                                has_done = 1'b1;
                                done_st  = dop_pkg::ST_DGRAM_END;
                            end
                        end
                        else begin
                            gather_next = g;
                            count_next  = c;
                            left_next   = left;
                            if (last) begin
                                has_done = 1'b1;
                                done_st  = dop_pkg::ST_OVERRUN;
                            end
                        end
                    end
                    default:
                    begin
                        if (b == dop_pkg::CODE_PAD) begin
                            if (last) begin
                                has_done = 1'b1;
                                done_st  = dop_pkg::ST_DGRAM_END;
                            end
                        end
                        else if (b == dop_pkg::CODE_END) begin
                            has_done = 1'b1;
                            done_st  = dop_pkg::ST_END_SEEN;
                        end
                        else begin
                            code_next  = b;
                            phase_next = PH_LEN;
                            if (last) begin
                                has_done = 1'b1;
                                done_st  = dop_pkg::ST_OVERRUN;
                            end
                        end
                    end
                endcase
                if (has_done) begin
                    clear        = 1'b1;
                    stopped_next = !last;
                end
            end
        end

        if (clear) begin
            phase_next  = PH_CODE;
            code_next   = 8'd0;
            left_next   = 8'd0;
            gather_next = 32'd0;
            count_next  = 3'd0;
        end

        push = '0;
        if (has_param) begin
            push.first = p;
            if (has_done) begin
                push.second           = done_item(done_st);
                push.second.final_res = 1'b1;
                push.count            = 2'd2;
            end
            else begin
                push.first.final_res = 1'b1;
                push.count           = 2'd1;
            end
        end
        else if (has_done) begin
            push.first           = done_item(done_st);
            push.first.final_res = 1'b1;
            push.count           = 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= PH_CODE;
            code_reg    <= 8'd0;
            left_reg    <= 8'd0;
            gather_reg  <= 32'd0;
            count_reg   <= 3'd0;
            stopped_reg <= 1'b0;
        end
        else begin
            phase_reg   <= phase_next;
            code_reg    <= code_next;
            left_reg    <= left_next;
            gather_reg  <= gather_next;
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

/* design/dop_res_queue.sv */
// Small result queue that takes up to two results per cycle and hands out
// one per transfer. Depends on dop_pkg.
module dop_res_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  dop_pkg::res_push_t push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output dop_pkg::res_item_t out_item
);

    dop_pkg::res_item_t mem [dop_pkg::RES_DEPTH];

    logic [dop_pkg::RES_PTR_W-1:0] wr_reg, wr_next;
    logic [dop_pkg::RES_PTR_W-1:0] rd_reg, rd_next;
    logic [dop_pkg::RES_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          pop;

    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem[rd_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (cnt_reg <= dop_pkg::RES_CNT_W'(dop_pkg::RES_DEPTH - 2));

    always_comb
    begin
        wr_next  = wr_reg + dop_pkg::RES_PTR_W'(push.count);
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + dop_pkg::RES_CNT_W'(push.count)
                   - dop_pkg::RES_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0) begin
            mem[wr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_reg + 1'b1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* design/dhcp_option_parser.sv */
// DHCP options area parser: one option byte per transfer in, parameter and
// done results out. Depends on dop_pkg, dop_if, dop_step and dop_res_queue.
// Results wait in the four-entry result queue; bytes are taken only while it holds two or fewer.
// Throughput: one byte per cycle while there is room; the queue absorbs bytes giving two results.
// Reset clears the parse state and empties the result queue.
module dhcp_option_parser (
    input  logic             clk,
    input  logic             rst_n,
    dop_opt_if.sink          options,
    dop_res_if.source        results
);

    dop_pkg::opt_item_t item;
    dop_pkg::res_push_t push;
    dop_pkg::res_item_t out_item;
    logic               room;
    logic               accept;

    assign item.option_byte = options.option_byte;
    assign item.last_byte   = options.last_byte;
    assign options.ready    = room;
    assign accept           = options.valid && room;

    dop_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push   (push)
    );

    dop_res_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_item  (out_item)
    );

    assign results.kind      = out_item.kind;
    assign results.value     = out_item.value;
    assign results.status    = out_item.status;
    assign results.final_res = out_item.final_res;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the DHCP options parser: directed and random datagrams,
// predicted results compared transfer by transfer under varying idle and stall rates.
// Depends on dop_pkg, the dop_opt_if and dop_res_if interfaces and dhcp_option_parser.
module tb_top;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_BYTES_PER_PHASE = 195;

    localparam logic [7:0] CODE_MASK      = 8'd1;
    localparam logic [7:0] CODE_OFFSET    = 8'd2;
    localparam logic [7:0] CODE_ROUTER    = 8'd3;
    localparam logic [7:0] CODE_TIME_SRV  = 8'd4;
    localparam logic [7:0] CODE_NAME_SRV  = 8'd5;
    localparam logic [7:0] CODE_DNS       = 8'd6;
    localparam logic [7:0] CODE_LOG       = 8'd7;
    localparam logic [7:0] CODE_COOKIE    = 8'd8;
    localparam logic [7:0] CODE_LPR       = 8'd9;
    localparam logic [7:0] CODE_DOMAIN    = 8'd15;
    localparam logic [7:0] CODE_MESSAGE   = 8'd56;
    localparam logic [7:0] CODE_MAX_SIZE  = 8'd57;
    localparam logic [7:0] CODE_CLIENT_ID = 8'd61;

    localparam logic [7:0] LEN_RULES [1:61] = '{
        CODE_MASK:             dop_pkg::RULE_MULT4,
        CODE_OFFSET:           dop_pkg::RULE_MULT2,
        CODE_ROUTER:           dop_pkg::RULE_MULT4,
        CODE_TIME_SRV:         dop_pkg::RULE_MULT4,
        CODE_NAME_SRV:         dop_pkg::RULE_MULT4,
        CODE_DNS:              dop_pkg::RULE_MULT4,
        CODE_LOG:              dop_pkg::RULE_MULT4,
        CODE_COOKIE:           dop_pkg::RULE_MULT4,
        CODE_LPR:              dop_pkg::RULE_MULT4,
        CODE_DOMAIN:           dop_pkg::RULE_MIN1,
        dop_pkg::CODE_MSGTYPE: dop_pkg::RULE_MULT1,
        dop_pkg::CODE_SERVER:  dop_pkg::RULE_MULT4,
        CODE_MESSAGE:          dop_pkg::RULE_MIN1,
        CODE_MAX_SIZE:         dop_pkg::RULE_MULT2,
        dop_pkg::CODE_RENEW:   dop_pkg::RULE_MULT4,
        dop_pkg::CODE_REBIND:  dop_pkg::RULE_MULT4,
        CODE_CLIENT_ID:        dop_pkg::RULE_MIN2,
        default:               dop_pkg::RULE_NONE
    };

    localparam logic [7:0] KNOWN_CODES [14] = '{
        CODE_MASK, CODE_OFFSET, CODE_ROUTER, CODE_TIME_SRV, CODE_NAME_SRV, CODE_DNS,
        CODE_LOG, CODE_COOKIE, CODE_LPR, dop_pkg::CODE_LEASE, dop_pkg::CODE_MSGTYPE,
        dop_pkg::CODE_SERVER, dop_pkg::CODE_RENEW, dop_pkg::CODE_REBIND
    };

    typedef enum logic [1:0] {
        WAIT_CODE = 2'd0,
        WAIT_LEN  = 2'd1,
        IN_VALUE  = 2'd2,
        PH_SPARE  = 2'd3
    } parse_phase_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain;
    } pending_byte_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       tx_valid = 1'b0;
    logic [7:0] tx_byte = 8'd0;
    logic       tx_last = 1'b0;
    logic       rx_ready = 1'b0;

    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned random_bytes = 0;
    int unsigned step_results;
    bit          drain_next = 1'b0;

    pending_byte_t      pending_bytes [$];
    dop_pkg::res_item_t expected_results [$];

    parse_phase_t parse_phase = WAIT_CODE;
    logic [7:0]   cur_code = 8'd0;
    logic [7:0]   bytes_left = 8'd0;
    logic [31:0]  gather = 32'd0;
    logic [2:0]   gather_count = 3'd0;
    logic         parser_stopped = 1'b0;

    dop_opt_if opt_ch ();
    dop_res_if res_ch ();

    assign opt_ch.valid       = tx_valid;
    assign opt_ch.option_byte = tx_byte;
    assign opt_ch.last_byte   = tx_last;
    assign res_ch.ready       = rx_ready;

    dhcp_option_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .options (opt_ch),
        .results (res_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit len_accepted(input logic [7:0] code, input logic [7:0] len);
        logic [7:0] rule;
        logic [6:0] elem;
        if (code == dop_pkg::CODE_PAD || code > dop_pkg::CODE_LAST_CHK)
        begin
            return 1'b1;
        end
        rule = LEN_RULES[code];
        if (rule[7])
        begin
            elem = rule[6:0];
            if (len == 8'd0)
            begin
                return 1'b0;
            end
            if (elem == 7'd0)
            begin
                return 1'b1;
            end
            return (len % elem) == 0;
        end
        return len >= rule;
    endfunction

    function automatic logic [3:0] param_kind(input logic [7:0] code);
        if (code >= CODE_MASK && code <= CODE_LPR)
        begin
            return 4'(code - CODE_MASK);
        end
        case (code)
            dop_pkg::CODE_LEASE:   return dop_pkg::KIND_LEASE;
            dop_pkg::CODE_MSGTYPE: return dop_pkg::KIND_MSGTYPE;
            dop_pkg::CODE_SERVER:  return dop_pkg::KIND_SERVER;
            dop_pkg::CODE_RENEW:   return dop_pkg::KIND_RENEW;
            dop_pkg::CODE_REBIND:  return dop_pkg::KIND_REBIND;
            default:               return dop_pkg::KIND_NONE;
        endcase
    endfunction

    task automatic push_result(input logic [3:0] kind, input logic [31:0] value,
                               input logic [1:0] status);
        dop_pkg::res_item_t item;
        item.kind      = kind;
        item.value     = value;
        item.status    = status;
        item.final_res = 1'b0;
        expected_results.push_back(item);
        step_results++;
    endtask

    task automatic clear_record();
        parse_phase  = WAIT_CODE;
        cur_code     = 8'd0;
        bytes_left   = 8'd0;
        gather       = 32'd0;
        gather_count = 3'd0;
    endtask

    task automatic end_message(input logic [1:0] status, input logic last);
        push_result(dop_pkg::KIND_DONE, 32'd0, status);
        clear_record();
        parser_stopped = !last;
    endtask

    task automatic emit_param();
        logic [3:0]  kind;
        logic [31:0] value;
        int unsigned n;
        kind = param_kind(cur_code);
        n = (gather_count > 3'd4) ? 4 : gather_count;
        if (kind == dop_pkg::KIND_NONE)
        begin
            return;
        end
        if (n == 0)
        begin
            value = 32'd0;
        end
        else if (kind == dop_pkg::KIND_MSGTYPE)
        begin
            value = (gather >> (8 * (n - 1))) & 32'hFF;
        end
        else if (n == 4)
        begin
            value = gather;
        end
        else
        begin
            value = gather << (8 * (4 - n));
        end
        push_result(kind, value, 2'd0);
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        step_results = 0;
        if (parser_stopped)
        begin
            if (last)
            begin
                parser_stopped = 1'b0;
                clear_record();
            end
            return;
        end
        case (parse_phase)
            WAIT_LEN:
            begin
                if (last && b != 8'd0)
                begin
                    end_message(dop_pkg::ST_OVERRUN, 1'b1);
                end
                else if (!len_accepted(cur_code, b))
                begin
                    end_message(dop_pkg::ST_BAD_LENGTH, last);
                end
                else if (b == 8'd0)
                begin
                    gather = 32'd0;
                    gather_count = 3'd0;
                    emit_param();
                    clear_record();
                    if (last)
                    begin
                        end_message(dop_pkg::ST_DGRAM_END, 1'b1);
                    end
                end
                else
                begin
                    bytes_left = b;
                    gather = 32'd0;
                    gather_count = 3'd0;
                    parse_phase = IN_VALUE;
                end
            end
            IN_VALUE:
            begin
                if (gather_count < 3'd4)
                begin
                    gather = (gather << 8) | b;
                    gather_count++;
                end
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0)
                begin
                    emit_param();
                    clear_record();
                    if (last)
                    begin
                        end_message(dop_pkg::ST_DGRAM_END, 1'b1);
                    end
                end
                else if (last)
                begin
                    end_message(dop_pkg::ST_OVERRUN, 1'b1);
                end
            end
            default:
            begin
                if (b == dop_pkg::CODE_PAD)
                begin
                    if (last)
                    begin
                        end_message(dop_pkg::ST_DGRAM_END, 1'b1);
                    end
                end
                else if (b == dop_pkg::CODE_END)
                begin
                    end_message(dop_pkg::ST_END_SEEN, last);
                end
                else
                begin
                    cur_code = b;
                    parse_phase = WAIT_LEN;
                    if (last)
                    begin
                        end_message(dop_pkg::ST_OVERRUN, 1'b1);
                    end
                end
            end
        endcase
        if (step_results > 0)
        begin
            expected_results[expected_results.size() - 1].final_res = 1'b1;
        end
    endtask

    task automatic queue_byte(input logic [7:0] data, input logic last);
        pending_byte_t item;
        item.data  = data;
        item.last  = last;
        item.drain = drain_next;
        drain_next = 1'b0;
        pending_bytes.push_back(item);
    endtask

    function automatic int legal_len(input logic [7:0] code);
        logic [7:0] rule;
        rule = LEN_RULES[code];
        if (rule[7])
        begin
            return int'(rule[6:0]) * $urandom_range(1, 3);
        end
        return int'(rule) + $urandom_range(0, 6);
    endfunction

    task automatic queue_datagram();
        logic [7:0] body [$];
        logic [7:0] code;
        int         n_rec;
        int         r;
        int         len;
        int         cut;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 8)) body.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            n_rec = $urandom_range(1, 4);
            for (int i = 0; i < n_rec; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    code = KNOWN_CODES[$urandom_range(0, 13)];
                    len = legal_len(code);
                end
                else if (r < 65)
                begin
                    if (r < 58)
                    begin
                        code = 8'($urandom_range(CODE_LPR + 1, dop_pkg::CODE_LAST_CHK));
                    end
                    else
                    begin
                        code = 8'($urandom_range(dop_pkg::CODE_LAST_CHK + 1,
                                                 dop_pkg::CODE_END - 1));
                    end
                    len = ($urandom_range(0, 49) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, 6);
                end
                else if (r < 75)
                begin
                    body.push_back(dop_pkg::CODE_PAD);
                    continue;
                end
                else if (r < 88)
                begin
                    code = KNOWN_CODES[$urandom_range(0, 13)];
                    len = $urandom_range(0, 9);
                end
                else
                begin
                    body.push_back(8'($urandom_range(0, 255)));
                    continue;
                end
                body.push_back(code);
                body.push_back(8'(len));
                repeat (len) body.push_back(8'($urandom_range(0, 255)));
            end
        end
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            body.push_back(dop_pkg::CODE_END);
            repeat ($urandom_range(0, 3)) body.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 70)
        begin
            body.push_back(dop_pkg::CODE_PAD);
        end
        else if (r >= 80)
        begin
            cut = $urandom_range(1, body.size());
            body = body[0:cut - 1];
        end
        foreach (body[i])
        begin
            queue_byte(body[i], i == body.size() - 1);
        end
        random_bytes += body.size();
    endtask

    task automatic queue_directed();
        queue_byte(CODE_MASK, 1'b0);
        queue_byte(8'd4, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_byte(dop_pkg::CODE_MSGTYPE, 1'b0);
        queue_byte(8'd2, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(dop_pkg::CODE_LEASE, 1'b0);
        queue_byte(8'd0, 1'b0);
        queue_byte(dop_pkg::CODE_END, 1'b0);
        queue_byte(CODE_LPR, 1'b0);
        queue_byte(dop_pkg::CODE_PAD, 1'b1);
        queue_byte(CODE_OFFSET, 1'b0);
        queue_byte(8'd0, 1'b1);
        queue_byte(CODE_ROUTER, 1'b0);
        queue_byte(8'd8, 1'b1);
        queue_byte(dop_pkg::CODE_END, 1'b1);
        queue_byte(dop_pkg::CODE_PAD, 1'b1);
        queue_byte(CODE_NAME_SRV, 1'b1);
        queue_byte(dop_pkg::CODE_LEASE, 1'b0);
        queue_byte(8'd5, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h02, 1'b0);
        queue_byte(8'h03, 1'b0);
        queue_byte(8'h04, 1'b0);
        queue_byte(8'hEE, 1'b1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : option_driver
        logic          accepted;
        logic          offer;
        pending_byte_t head;
        if (!rst_n)
        begin
            tx_valid <= 1'b0;
            tx_byte  <= 8'd0;
            tx_last  <= 1'b0;
        end
        else
        begin
            accepted = tx_valid && opt_ch.ready;
            if (accepted)
            begin
                predict_byte(tx_byte, tx_last);
            end
            if (accepted || !tx_valid)
            begin
                offer = pending_bytes.size() != 0 && $urandom_range(0, 99) >= idle_pct;
                if (offer && pending_bytes[0].drain && expected_results.size() != 0)
                begin
                    offer = 1'b0;
                end
                if (offer)
                begin
                    head = pending_bytes.pop_front();
                    tx_byte <= head.data;
                    tx_last <= head.last;
                end
                tx_valid <= offer;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        dop_pkg::res_item_t got;
        dop_pkg::res_item_t want;
        if (!rst_n)
        begin
            rx_ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && rx_ready)
            begin
                got.kind      = res_ch.kind;
                got.value     = res_ch.value;
                got.status    = res_ch.status;
                got.final_res = res_ch.final_res;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result kind %0d value %h status %0d final %0d",
                             $time, got.kind, got.value, got.status, got.final_res);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.value !== want.value ||
                        got.status !== want.status || got.final_res !== want.final_res)
                    begin
                        mismatches++;
                        $display({"%0t: result mismatch: expected kind %0d value %h ",
                                  "status %0d final %0d, got kind %0d value %h ",
                                  "status %0d final %0d"},
                                 $time, want.kind, want.value, want.status,
                                 want.final_res, got.kind, got.value, got.status,
                                 got.final_res);
                    end
                end
            end
            rx_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("dhcp_option_parser verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 46;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 46;
                end
                default:
                begin
                    idle_pct  = 26;
                    stall_pct = 26;
                end
            endcase
            if (ph == 0)
            begin
                queue_directed();
            end
            drain_next = 1'b1;
            random_bytes = 0;
            while (random_bytes < RANDOM_BYTES_PER_PHASE)
            begin
                queue_datagram();
            end
            while (pending_bytes.size() != 0 || tx_valid || expected_results.size() != 0)
            begin
                @(posedge clk);
            end
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("dhcp_option_parser verification clean");
        end
        else
        begin
            $display("dhcp_option_parser verification failed");
        end
        $finish;
    end

endmodule
